FILE: rtl/qs_pkg.sv
`timescale 1ns / 1ps
// qs_pkg: widths, constants, side-band type and arctangent table for the
// quaternion slerp pipeline. No dependencies.
package qs_pkg;

    localparam int COMP_W       = 16;
    localparam int T_W          = 15;
    localparam int FRAC_BITS    = 14;
    localparam int Q            = 30;
    localparam int C_W          = Q + 1;
    localparam int P_W          = 2 * COMP_W;
    localparam int DOT_W        = P_W + 2;
    localparam int C_SH         = Q - 2 * FRAC_BITS;
    localparam int SQ_W         = 2 * Q + 2;
    localparam int SQ_STEPS     = Q + 1;
    localparam int CX_W         = Q + 4;
    localparam int CZ_W         = Q + 3;
    localparam int CORDIC_STEPS = Q;
    localparam int DIV_W        = C_W + Q;
    localparam int REM_W        = C_W;
    localparam int WT_W         = DIV_W + 1;
    localparam int PA_W         = WT_W + COMP_W;
    localparam int PB_W         = PA_W + 1;
    localparam int ACC_W        = PB_W + 1;
    localparam int T_SH         = Q - FRAC_BITS;

    localparam logic [T_W-1:0]  THR_RST     = T_W'(16368);
    localparam logic [CX_W-1:0] CORDIC_GAIN = CX_W'(652032874);

    typedef struct packed {
        logic                         lin;
        logic [C_W-1:0]               t30;
        logic [C_W-1:0]               c;
        logic [C_W-1:0]               s;
        logic [3:0][COMP_W-1:0]       a;
        logic [3:0][COMP_W:0]         b;
    } t_side;

    function automatic logic [CZ_W-1:0] atan_step(input int i);
        logic [CZ_W-1:0] v;
        case (i)
            0:       v = CZ_W'(843314857);
            1:       v = CZ_W'(497837829);
            2:       v = CZ_W'(263043837);
            3:       v = CZ_W'(133525159);
            4:       v = CZ_W'(67021687);
            5:       v = CZ_W'(33543516);
            6:       v = CZ_W'(16775851);
            7:       v = CZ_W'(8388437);
            8:       v = CZ_W'(4194283);
            9:       v = CZ_W'(2097149);
            default: v = CZ_W'(1) << (Q - i);
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/qs_if.sv
`timescale 1ns / 1ps
// qs_req_if / qs_res_if: valid-ready channels for slerp requests and results.
// Depends on qs_pkg for field widths.
interface qs_req_if;
    logic                               valid;
    logic                               ready;
    logic signed [qs_pkg::COMP_W-1:0]   first_x;
    logic signed [qs_pkg::COMP_W-1:0]   first_y;
    logic signed [qs_pkg::COMP_W-1:0]   first_z;
    logic signed [qs_pkg::COMP_W-1:0]   first_w;
    logic signed [qs_pkg::COMP_W-1:0]   second_x;
    logic signed [qs_pkg::COMP_W-1:0]   second_y;
    logic signed [qs_pkg::COMP_W-1:0]   second_z;
    logic signed [qs_pkg::COMP_W-1:0]   second_w;
    logic        [qs_pkg::T_W-1:0]      blend_t;

    modport source (
        output valid, first_x, first_y, first_z, first_w,
        output second_x, second_y, second_z, second_w, blend_t,
        input  ready
    );
    modport sink (
        input  valid, first_x, first_y, first_z, first_w,
        input  second_x, second_y, second_z, second_w, blend_t,
        output ready
    );
endinterface

interface qs_res_if;
    logic                               valid;
    logic                               ready;
    logic signed [qs_pkg::COMP_W-1:0]   out_x;
    logic signed [qs_pkg::COMP_W-1:0]   out_y;
    logic signed [qs_pkg::COMP_W-1:0]   out_z;
    logic signed [qs_pkg::COMP_W-1:0]   out_w;

    modport source (output valid, out_x, out_y, out_z, out_w, input ready);
    modport sink   (input  valid, out_x, out_y, out_z, out_w, output ready);
endinterface

FILE: rtl/qs_sqrt_cell.sv
`timescale 1ns / 1ps
// qs_sqrt_cell: one step of the bit-pair integer square root, registered.
// Depends on qs_pkg.
module qs_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_vld,
    input  qs_pkg::t_side            i_side,
    input  logic [qs_pkg::SQ_W-1:0]  i_rem,
    input  logic [qs_pkg::SQ_W-1:0]  i_root,
    output logic                     o_vld,
    output qs_pkg::t_side            o_side,
    output logic [qs_pkg::SQ_W-1:0]  o_rem,
    output logic [qs_pkg::SQ_W-1:0]  o_root
);
    import qs_pkg::*;

    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_STEPS - 1 - STEP));

    logic            r_vld;
    t_side           r_side;
    logic [SQ_W-1:0] r_rem, r_root;
    logic [SQ_W-1:0] trial, n_rem, n_root;
    logic            ge;

    assign trial  = i_root + BIT;
    assign ge     = i_rem >= trial;
    assign n_rem  = ge ? i_rem - trial : i_rem;
    assign n_root = ge ? (i_root >> 1) + BIT : i_root >> 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_vld  = r_vld;
    assign o_side = r_side;
    assign o_rem  = r_rem;
    assign o_root = r_root;
endmodule

FILE: rtl/qs_cordic_cell.sv
`timescale 1ns / 1ps
// qs_cordic_cell: one CORDIC micro-rotation for one or more lanes, in vectoring
// or rotation mode, registered. Depends on qs_pkg.
module qs_cordic_cell #(
    parameter int STEP  = 0,
    parameter bit VEC   = 1'b0,
    parameter int LANES = 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_vld,
    input  qs_pkg::t_side                       i_side,
    input  logic [LANES-1:0][qs_pkg::CX_W-1:0]  i_x,
    input  logic [LANES-1:0][qs_pkg::CX_W-1:0]  i_y,
    input  logic [LANES-1:0][qs_pkg::CZ_W-1:0]  i_z,
    output logic                                o_vld,
    output qs_pkg::t_side                       o_side,
    output logic [LANES-1:0][qs_pkg::CX_W-1:0]  o_x,
    output logic [LANES-1:0][qs_pkg::CX_W-1:0]  o_y,
    output logic [LANES-1:0][qs_pkg::CZ_W-1:0]  o_z
);
    import qs_pkg::*;

    localparam logic [CZ_W-1:0] ATAN = atan_step(STEP);

    logic                        r_vld;
    t_side                       r_side;
    logic [LANES-1:0][CX_W-1:0]  r_x, r_y, n_x, n_y;
    logic [LANES-1:0][CZ_W-1:0]  r_z, n_z;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic signed [CX_W-1:0] xs, ys;
        logic                   add;
        assign xs  = $signed(i_x[l]) >>> STEP;
        assign ys  = $signed(i_y[l]) >>> STEP;
        assign add = VEC ? ~i_y[l][CX_W-1] : i_z[l][CZ_W-1];
        assign n_x[l] = add ? i_x[l] + ys : i_x[l] - ys;
        assign n_y[l] = add ? i_y[l] - xs : i_y[l] + xs;
        assign n_z[l] = add ? i_z[l] + ATAN : i_z[l] - ATAN;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
        end
    end

    assign o_vld  = r_vld;
    assign o_side = r_side;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
endmodule

FILE: rtl/qs_div_cell.sv
`timescale 1ns / 1ps
// qs_div_cell: one restoring division step per lane, one quotient bit each,
// registered. Depends on qs_pkg.
module qs_div_cell #(
    parameter int LANES = 2
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_vld,
    input  qs_pkg::t_side                        i_side,
    input  logic [qs_pkg::REM_W-1:0]             i_den,
    input  logic [LANES-1:0]                     i_neg,
    input  logic [LANES-1:0][qs_pkg::REM_W-1:0]  i_rem,
    input  logic [LANES-1:0][qs_pkg::DIV_W-1:0]  i_nq,
    output logic                                 o_vld,
    output qs_pkg::t_side                        o_side,
    output logic [LANES-1:0]                     o_neg,
    output logic [LANES-1:0][qs_pkg::REM_W-1:0]  o_rem,
    output logic [LANES-1:0][qs_pkg::DIV_W-1:0]  o_nq
);
    import qs_pkg::*;

    logic                         r_vld;
    t_side                        r_side;
    logic [LANES-1:0]             r_neg;
    logic [LANES-1:0][REM_W-1:0]  r_rem, n_rem;
    logic [LANES-1:0][DIV_W-1:0]  r_nq, n_nq;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic [REM_W:0] tr, diff;
        logic           ge;
        assign tr       = {i_rem[l], i_nq[l][DIV_W-1]};
        assign diff     = tr - {1'b0, i_den};
        assign ge       = tr >= {1'b0, i_den};
        assign n_rem[l] = ge ? diff[REM_W-1:0] : tr[REM_W-1:0];
        assign n_nq[l]  = {i_nq[l][DIV_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_neg  <= i_neg;
            r_rem  <= n_rem;
            r_nq   <= n_nq;
        end
    end

    assign o_vld  = r_vld;
    assign o_side = r_side;
    assign o_neg  = r_neg;
    assign o_rem  = r_rem;
    assign o_nq   = r_nq;
endmodule

FILE: rtl/quaternion_slerp.sv
`timescale 1ns / 1ps
// quaternion_slerp: fixed-point spherical blend of two unit quaternions.
// Depends on qs_pkg, qs_if, qs_sqrt_cell, qs_cordic_cell and qs_div_cell.
//
// Takes one request per clock while results are taken and returns one result
// for each accepted request. The pipeline is a chain of cells: 31 square-root
// cells, 30 vectoring CORDIC cells, 30 rotation CORDIC cells (both sines side
// by side) and 61 divider cells (both weights side by side), plus eight stages
// of dot product, multiplies and output rounding; the divider chain is the
// longest. The whole chain stalls together when a finished result is not
// taken. lerp_threshold may only be written while no request is in flight.
module quaternion_slerp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [qs_pkg::T_W-1:0]    i_cfg_data,
    qs_req_if.sink                    i_req,
    qs_res_if.source                  o_res
);
    import qs_pkg::*;

    localparam logic [T_W-1:0]   T_ONE   = T_W'(1) << FRAC_BITS;
    localparam logic [DOT_W-1:0] ONE2    = DOT_W'(1) << (2 * FRAC_BITS);
    localparam logic [SQ_W-1:0]  RAD_ONE = SQ_W'(1) << (2 * Q);
    localparam logic [C_W-1:0]   Q_ONE   = C_W'(1) << Q;
    localparam int               MP_W    = 2 * C_W;
    localparam int               RS_W    = ACC_W - Q;
    localparam logic signed [ACC_W-1:0] ROUND  = ACC_W'(1) << (Q - 1);
    localparam logic signed [RS_W-1:0]  SAT_HI = RS_W'(32767);
    localparam logic signed [RS_W-1:0]  SAT_LO = -RS_W'(32768);

    logic en;
    logic [T_W-1:0] r_thr;

    // stage 1: products
    logic                     r1_vld;
    t_side                    n1_side, r1_side;
    logic signed [P_W-1:0]    n1_p [4];
    logic signed [P_W-1:0]    r1_p [4];
    logic [T_W-1:0]           t_sat;

    // stage 2: dot product, fold, clamp
    logic                     r2_vld;
    t_side                    n2_side, r2_side;
    logic signed [DOT_W-1:0]  dot;
    logic [DOT_W-1:0]         adot, dotc;
    logic                     dneg;

    // stage 3: radicand
    logic                     r3_vld;
    t_side                    r3_side;
    logic [SQ_W-1:0]          r3_rad;

    // chains
    logic                        sq_vld  [SQ_STEPS+1];
    t_side                       sq_side [SQ_STEPS+1];
    logic [SQ_W-1:0]             sq_rem  [SQ_STEPS+1];
    logic [SQ_W-1:0]             sq_root [SQ_STEPS+1];

    t_side                       vc_side0;
    logic                        vc_vld  [CORDIC_STEPS+1];
    t_side                       vc_side [CORDIC_STEPS+1];
    logic [0:0][CX_W-1:0]        vc_x    [CORDIC_STEPS+1];
    logic [0:0][CX_W-1:0]        vc_y    [CORDIC_STEPS+1];
    logic [0:0][CZ_W-1:0]        vc_z    [CORDIC_STEPS+1];

    // stage M: angles
    logic                     rm_vld;
    t_side                    rm_side;
    logic [C_W-1:0]           om, rm_a0, rm_a1;
    logic [CZ_W-1:0]          zl;
    logic [MP_W-1:0]          prod0, prod1;

    logic                        rt_vld  [CORDIC_STEPS+1];
    t_side                       rt_side [CORDIC_STEPS+1];
    logic [1:0][CX_W-1:0]        rt_x    [CORDIC_STEPS+1];
    logic [1:0][CX_W-1:0]        rt_y    [CORDIC_STEPS+1];
    logic [1:0][CZ_W-1:0]        rt_z    [CORDIC_STEPS+1];

    // stage P: divider operands
    logic                     rp_vld;
    t_side                    rp_side;
    logic [1:0]               n_p_neg, rp_neg;
    logic [1:0][CX_W-1:0]     n_p_mag;
    logic [1:0][DIV_W-1:0]    n_p_nq, rp_nq;

    logic                        dv_vld  [DIV_W+1];
    t_side                       dv_side [DIV_W+1];
    logic [1:0]                  dv_neg  [DIV_W+1];
    logic [1:0][REM_W-1:0]       dv_rem  [DIV_W+1];
    logic [1:0][DIV_W-1:0]       dv_nq   [DIV_W+1];

    // final stages
    logic                     rf1_vld, rf2_vld, r_out_vld;
    t_side                    rf1_side;
    logic signed [WT_W-1:0]   n_w [2];
    logic signed [WT_W-1:0]   r_w [2];
    logic signed [PA_W-1:0]   n_pa [4];
    logic signed [PA_W-1:0]   r_pa [4];
    logic signed [PB_W-1:0]   n_pb [4];
    logic signed [PB_W-1:0]   r_pb [4];
    logic signed [ACC_W-1:0]  acc  [4];
    logic signed [RS_W-1:0]   rs   [4];
    logic [COMP_W-1:0]        n_out [4];
    logic [COMP_W-1:0]        r_out [4];

    assign en          = ~r_out_vld | o_res.ready;
    assign i_req.ready = en;

    // stage 1
    assign t_sat = (i_req.blend_t > T_ONE) ? T_ONE : i_req.blend_t;

    always_comb begin
        n1_side      = '0;
        n1_side.a[0] = i_req.first_x;
        n1_side.a[1] = i_req.first_y;
        n1_side.a[2] = i_req.first_z;
        n1_side.a[3] = i_req.first_w;
        n1_side.b[0] = {i_req.second_x[COMP_W-1], i_req.second_x};
        n1_side.b[1] = {i_req.second_y[COMP_W-1], i_req.second_y};
        n1_side.b[2] = {i_req.second_z[COMP_W-1], i_req.second_z};
        n1_side.b[3] = {i_req.second_w[COMP_W-1], i_req.second_w};
        n1_side.t30  = C_W'(t_sat) << T_SH;
        n1_p[0]      = i_req.first_x * i_req.second_x;
        n1_p[1]      = i_req.first_y * i_req.second_y;
        n1_p[2]      = i_req.first_z * i_req.second_z;
        n1_p[3]      = i_req.first_w * i_req.second_w;
    end

    // stage 2
    assign dot  = r1_p[0] + r1_p[1] + r1_p[2] + r1_p[3];
    assign dneg = dot[DOT_W-1];
    assign adot = dneg ? DOT_W'(-dot) : DOT_W'(dot);
    assign dotc = (adot > ONE2) ? ONE2 : adot;

    always_comb begin
        n2_side = r1_side;
        for (int k = 0; k < 4; k++) begin
            if (dneg) begin
                n2_side.b[k] = -r1_side.b[k];
            end
        end
        n2_side.c   = C_W'(dotc << C_SH);
        n2_side.lin = ~(dotc < (DOT_W'(r_thr) << FRAC_BITS));
    end

    // square root chain
    assign sq_vld[0]  = r3_vld;
    assign sq_side[0] = r3_side;
    assign sq_rem[0]  = r3_rad;
    assign sq_root[0] = '0;

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        qs_sqrt_cell #(.STEP(k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (sq_vld[k]),
            .i_side  (sq_side[k]),
            .i_rem   (sq_rem[k]),
            .i_root  (sq_root[k]),
            .o_vld   (sq_vld[k+1]),
            .o_side  (sq_side[k+1]),
            .o_rem   (sq_rem[k+1]),
            .o_root  (sq_root[k+1])
        );
    end

    // vectoring chain
    always_comb begin
        vc_side0     = sq_side[SQ_STEPS];
        vc_side0.s   = sq_root[SQ_STEPS][C_W-1:0];
        vc_side0.lin = sq_side[SQ_STEPS].lin | (sq_root[SQ_STEPS] == '0);
    end

    assign vc_vld[0]  = sq_vld[SQ_STEPS];
    assign vc_side[0] = vc_side0;
    assign vc_x[0]    = CX_W'(vc_side0.c);
    assign vc_y[0]    = CX_W'(vc_side0.s);
    assign vc_z[0]    = '0;

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vec
        qs_cordic_cell #(.STEP(k), .VEC(1'b1), .LANES(1)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (vc_vld[k]),
            .i_side  (vc_side[k]),
            .i_x     (vc_x[k]),
            .i_y     (vc_y[k]),
            .i_z     (vc_z[k]),
            .o_vld   (vc_vld[k+1]),
            .o_side  (vc_side[k+1]),
            .o_x     (vc_x[k+1]),
            .o_y     (vc_y[k+1]),
            .o_z     (vc_z[k+1])
        );
    end

    // stage M
    assign zl    = vc_z[CORDIC_STEPS][0];
    assign om    = zl[CZ_W-1] ? '0 : zl[C_W-1:0];
    assign prod1 = MP_W'(vc_side[CORDIC_STEPS].t30) * MP_W'(om);
    assign prod0 = MP_W'(Q_ONE - vc_side[CORDIC_STEPS].t30) * MP_W'(om);

    // rotation chain, lane 0 gives sin of the first angle, lane 1 the second
    assign rt_vld[0]  = rm_vld;
    assign rt_side[0] = rm_side;
    assign rt_x[0]    = {CORDIC_GAIN, CORDIC_GAIN};
    assign rt_y[0]    = '0;
    assign rt_z[0]    = {CZ_W'(rm_a1), CZ_W'(rm_a0)};

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
        qs_cordic_cell #(.STEP(k), .VEC(1'b0), .LANES(2)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (rt_vld[k]),
            .i_side  (rt_side[k]),
            .i_x     (rt_x[k]),
            .i_y     (rt_y[k]),
            .i_z     (rt_z[k]),
            .o_vld   (rt_vld[k+1]),
            .o_side  (rt_side[k+1]),
            .o_x     (rt_x[k+1]),
            .o_y     (rt_y[k+1]),
            .o_z     (rt_z[k+1])
        );
    end

    // stage P
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_p_neg[l] = rt_y[CORDIC_STEPS][l][CX_W-1];
            n_p_mag[l] = n_p_neg[l] ? -rt_y[CORDIC_STEPS][l] : rt_y[CORDIC_STEPS][l];
            n_p_nq[l]  = DIV_W'(n_p_mag[l][C_W-1:0]) << Q;
        end
    end

    // divider chain
    assign dv_vld[0]  = rp_vld;
    assign dv_side[0] = rp_side;
    assign dv_neg[0]  = rp_neg;
    assign dv_rem[0]  = '0;
    assign dv_nq[0]   = rp_nq;

    for (genvar k = 0; k < DIV_W; k++) begin : g_div
        qs_div_cell #(.LANES(2)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (dv_vld[k]),
            .i_side  (dv_side[k]),
            .i_den   (dv_side[k].s),
            .i_neg   (dv_neg[k]),
            .i_rem   (dv_rem[k]),
            .i_nq    (dv_nq[k]),
            .o_vld   (dv_vld[k+1]),
            .o_side  (dv_side[k+1]),
            .o_neg   (dv_neg[k+1]),
            .o_rem   (dv_rem[k+1]),
            .o_nq    (dv_nq[k+1])
        );
    end

    // weights
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_w[l] = dv_neg[DIV_W][l] ? -WT_W'(dv_nq[DIV_W][l]) : WT_W'(dv_nq[DIV_W][l]);
        end
        if (dv_side[DIV_W].lin) begin
            n_w[0] = WT_W'(Q_ONE - dv_side[DIV_W].t30);
            n_w[1] = WT_W'(dv_side[DIV_W].t30);
        end
    end

    // weighted sum, round, saturate
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_pa[k] = r_w[0] * $signed(rf1_side.a[k]);
            n_pb[k] = r_w[1] * $signed(rf1_side.b[k]);
            acc[k]  = r_pa[k] + r_pb[k] + ROUND;
            rs[k]   = RS_W'(acc[k] >>> Q);
            if (rs[k] > SAT_HI) begin
                n_out[k] = SAT_HI[COMP_W-1:0];
            end else if (rs[k] < SAT_LO) begin
                n_out[k] = SAT_LO[COMP_W-1:0];
            end else begin
                n_out[k] = rs[k][COMP_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= THR_RST;
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            rm_vld    <= 1'b0;
            rp_vld    <= 1'b0;
            rf1_vld   <= 1'b0;
            rf2_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
            if (en) begin
                r1_vld    <= i_req.valid;
                r2_vld    <= r1_vld;
                r3_vld    <= r2_vld;
                rm_vld    <= vc_vld[CORDIC_STEPS];
                rp_vld    <= rt_vld[CORDIC_STEPS];
                rf1_vld   <= dv_vld[DIV_W];
                rf2_vld   <= rf1_vld;
                r_out_vld <= rf2_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_side  <= n1_side;
            r1_p     <= n1_p;
            r2_side  <= n2_side;
            r3_side  <= r2_side;
            r3_rad   <= RAD_ONE - SQ_W'(r2_side.c) * SQ_W'(r2_side.c);
            rm_side  <= vc_side[CORDIC_STEPS];
            rm_a0    <= prod0[Q +: C_W];
            rm_a1    <= prod1[Q +: C_W];
            rp_side  <= rt_side[CORDIC_STEPS];
            rp_neg   <= n_p_neg;
            rp_nq    <= n_p_nq;
            rf1_side <= dv_side[DIV_W];
            r_w      <= n_w;
            r_pa     <= n_pa;
            r_pb     <= n_pb;
            r_out    <= n_out;
        end
    end

    assign o_res.valid = r_out_vld;
    assign o_res.out_x = r_out[0];
    assign o_res.out_y = r_out[1];
    assign o_res.out_z = r_out[2];
    assign o_res.out_w = r_out[3];
endmodule
